>>> hw/rtl/tape_sector_framer_macros.svh
// Assertion macros used by the tape sector framer top level.
`ifndef TAPE_SECTOR_FRAMER_MACROS_SVH
`define TAPE_SECTOR_FRAMER_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define TSF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define TSF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> hw/rtl/tsf_pkg.sv
// Package with the constants and types of the tape sector framer.
package tsf_pkg;

    localparam int unsigned DATA_BYTES   = 512;
    localparam int unsigned FILLER_BYTES = 120;
    localparam int unsigned HEAD_BYTES   = 14;
    localparam int unsigned BLOCK_BYTES  = 2;
    localparam int unsigned HEAD_ZEROS   = 10;
    localparam int unsigned DATA_ZEROS   = 6;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned COUNT_W  = 7;
    localparam int unsigned SUM_W    = 16;
    localparam int unsigned POS_W    = 10;
    localparam int unsigned M_DATA_W = 16;
    localparam int unsigned KIND_W   = 6;

    localparam logic [POS_W-1:0] HEAD_LAST  = POS_W'(HEAD_BYTES - 1);
    localparam logic [POS_W-1:0] BLOCK_LAST = POS_W'(BLOCK_BYTES - 1);
    localparam logic [POS_W-1:0] DATA_LAST  = POS_W'(DATA_BYTES - 1);

    localparam logic [SUM_W-1:0]  SUM_INIT  = 16'h0F0F;
    localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;
    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] FILL_BYTE = 8'h5A;

    localparam logic [COUNT_W-1:0] HEAD_ZERO_COUNT = COUNT_W'(HEAD_ZEROS);
    localparam logic [COUNT_W-1:0] DATA_ZERO_COUNT = COUNT_W'(DATA_ZEROS);
    localparam logic [COUNT_W-1:0] SYNC_COUNT      = 7'd2;
    localparam logic [COUNT_W-1:0] SINGLE_COUNT    = 7'd1;
    localparam logic [COUNT_W-1:0] FILL_COUNT      = COUNT_W'(FILLER_BYTES);

    // Bit positions in the result mask, in emission order.
    localparam int unsigned KIND_ZERO = 0;
    localparam int unsigned KIND_SYNC = 1;
    localparam int unsigned KIND_DATA = 2;
    localparam int unsigned KIND_LO   = 3;
    localparam int unsigned KIND_HI   = 4;
    localparam int unsigned KIND_FILL = 5;

    typedef logic [KIND_W-1:0] kind_mask_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  data;
        logic [SUM_W-1:0]   sum;
        logic [COUNT_W-1:0] zeros;
        kind_mask_t         kinds;
    } job_t;

endpackage

>>> hw/rtl/tsf_sectioner.sv
// Section tracking, checksum and result planning for each accepted byte.
module tsf_sectioner (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [tsf_pkg::BYTE_W-1:0] s_tdata,   // [7:0] data_byte
    output logic                      job_valid,
    output tsf_pkg::job_t             job,
    input  logic                      job_ready
);

    typedef enum logic [1:0] {
        SEC_HEAD  = 2'd0,
        SEC_BLOCK = 2'd1,
        SEC_DATA  = 2'd2
    } section_t;

    section_t                        section_reg, section_next, sec;
    logic [tsf_pkg::POS_W-1:0]       pos_reg, pos_next, last_pos;
    logic [tsf_pkg::SUM_W-1:0]       sum_reg, sum_next, sum_base, sum_new;
    logic [tsf_pkg::COUNT_W-1:0]     zeros;
    logic                            job_valid_reg;
    tsf_pkg::job_t                   job_reg, job_next;
    logic                            accept, first, last;

    assign s_tready  = !job_valid_reg || job_ready;
    assign accept    = s_tvalid && s_tready;
    assign job_valid = job_valid_reg;
    assign job       = job_reg;

    always_comb begin
        // The unused section code is treated as the sector header.
        unique case (section_reg)
            SEC_BLOCK: begin
                sec      = SEC_BLOCK;
                last_pos = tsf_pkg::BLOCK_LAST;
                zeros    = tsf_pkg::HEAD_ZERO_COUNT;
            end
            SEC_DATA: begin
                sec      = SEC_DATA;
                last_pos = tsf_pkg::DATA_LAST;
                zeros    = tsf_pkg::DATA_ZERO_COUNT;
            end
            default: begin
                sec      = SEC_HEAD;
                last_pos = tsf_pkg::HEAD_LAST;
                zeros    = tsf_pkg::HEAD_ZERO_COUNT;
            end
        endcase

        first    = (pos_reg == '0);
        last     = (pos_reg >= last_pos);
        sum_base = first ? tsf_pkg::SUM_INIT : sum_reg;
        sum_new  = sum_base + {8'h00, s_tdata};

        job_next.data  = s_tdata;
        job_next.sum   = sum_new;
        job_next.zeros = zeros;
        job_next.kinds = '0;
        job_next.kinds[tsf_pkg::KIND_ZERO] = first;
        job_next.kinds[tsf_pkg::KIND_SYNC] = first;
        job_next.kinds[tsf_pkg::KIND_DATA] = 1'b1;
        job_next.kinds[tsf_pkg::KIND_LO]   = last;
        job_next.kinds[tsf_pkg::KIND_HI]   = last;
        job_next.kinds[tsf_pkg::KIND_FILL] = last && (sec == SEC_DATA);

        if (last) begin
            pos_next = '0;
            sum_next = tsf_pkg::SUM_INIT;
            unique case (sec)
                SEC_HEAD:  section_next = SEC_BLOCK;
                SEC_BLOCK: section_next = SEC_DATA;
                default:   section_next = SEC_HEAD;
            endcase
        end else begin
            pos_next     = pos_reg + 1'b1;
            sum_next     = sum_new;
            section_next = sec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            section_reg   <= SEC_HEAD;
            pos_reg       <= '0;
            sum_reg       <= tsf_pkg::SUM_INIT;
            job_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                section_reg <= section_next;
                pos_reg     <= pos_next;
                sum_reg     <= sum_next;
                job_reg     <= job_next;
            end
            if (s_tready) begin
                job_valid_reg <= s_tvalid;
            end
        end
    end

endmodule

>>> hw/rtl/tsf_emitter.sv
// Walks the planned results of each byte and drives the output register.
module tsf_emitter (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        job_valid,
    input  tsf_pkg::job_t               job,
    output logic                        job_ready,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [tsf_pkg::M_DATA_W-1:0] m_tdata,  // [7:0] out_byte, [14:8] repeat_count
    output logic                        m_tuser,  // [0] sector_done
    output logic                        m_tlast
);

    logic                          cur_valid_reg;
    tsf_pkg::job_t                 cur_reg;
    tsf_pkg::kind_mask_t           mask_reg, sel;
    logic                          out_free, last_slot;
    logic [tsf_pkg::BYTE_W-1:0]    res_byte;
    logic [tsf_pkg::COUNT_W-1:0]   res_count;
    logic                          m_tvalid_reg, m_tlast_reg, m_tuser_reg;
    logic [tsf_pkg::M_DATA_W-1:0]  m_tdata_reg;

    assign out_free  = !m_tvalid_reg || m_tready;
    // Lowest pending result first; the job is done when one bit remains.
    assign sel       = mask_reg & (~mask_reg + 1'b1);
    assign last_slot = ((mask_reg & (mask_reg - 1'b1)) == '0);
    assign job_ready = !cur_valid_reg || (out_free && last_slot);

    always_comb begin
        res_byte  = cur_reg.data;
        res_count = tsf_pkg::SINGLE_COUNT;
        if (sel[tsf_pkg::KIND_ZERO]) begin
            res_byte  = tsf_pkg::ZERO_BYTE;
            res_count = cur_reg.zeros;
        end else if (sel[tsf_pkg::KIND_SYNC]) begin
            res_byte  = tsf_pkg::SYNC_BYTE;
            res_count = tsf_pkg::SYNC_COUNT;
        end else if (sel[tsf_pkg::KIND_LO]) begin
            res_byte  = cur_reg.sum[7:0];
        end else if (sel[tsf_pkg::KIND_HI]) begin
            res_byte  = cur_reg.sum[15:8];
        end else if (sel[tsf_pkg::KIND_FILL]) begin
            res_byte  = tsf_pkg::FILL_BYTE;
            res_count = tsf_pkg::FILL_COUNT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (out_free) begin
                m_tvalid_reg <= cur_valid_reg;
                if (cur_valid_reg) begin
                    m_tdata_reg <= {1'b0, res_count, res_byte};
                    m_tuser_reg <= sel[tsf_pkg::KIND_FILL];
                    m_tlast_reg <= last_slot;
                end
            end
            if (job_ready) begin
                cur_valid_reg <= job_valid;
                cur_reg       <= job;
                mask_reg      <= job.kinds;
            end else if (out_free && cur_valid_reg) begin
                mask_reg      <= mask_reg & ~sel;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

>>> hw/rtl/tape_sector_framer.sv
// Top level of the tape sector framer: byte stream in, run-length results out.
//
//   channel  direction  tdata                              tuser        tlast
//   s_       in         [7:0] data_byte                    -            -
//   m_       out        [7:0] out_byte, [14:8] repeat_count [0] sector_done last_of_run
//
// Each byte gives one to four results: three on the first byte of a section,
// three or four on the last and one otherwise. The output register moves one
// result per cycle unless m_tready stalls. A byte passes the job register, the
// emitter's current-job register and the output register. Reset (aresetn low,
// synchronous) returns to the sector header with the checksum at its start
// value. A stall on m_tready holds the output register and backs up to s_tready.
`include "tape_sector_framer_macros.svh"

module tape_sector_framer (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [tsf_pkg::BYTE_W-1:0]   s_tdata,   // [7:0] data_byte
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [tsf_pkg::M_DATA_W-1:0] m_tdata,   // [7:0] out_byte, [14:8] repeat_count
    output logic                         m_tuser,   // [0] sector_done
    output logic                         m_tlast
);

    logic          job_valid, job_ready;
    tsf_pkg::job_t job;

    tsf_sectioner u_sectioner (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .job_valid (job_valid),
        .job       (job),
        .job_ready (job_ready)
    );

    tsf_emitter u_emitter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (job_valid),
        .job       (job),
        .job_ready (job_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // The filler run always closes the results of the last data byte.
    `TSF_ASSERT(a_fill_is_last, m_tvalid && m_tuser |-> m_tlast && (m_tdata[7:0] == tsf_pkg::FILL_BYTE), "filler run not last or wrong byte")
    // No result carries a zero repeat count.
    `TSF_ASSERT(a_count_nonzero, m_tvalid |-> (m_tdata[14:8] != '0), "zero repeat count")
    // A planned job waiting on the emitter must not change.
    `TSF_ASSERT(a_job_holds, job_valid && !job_ready |=> job_valid && $stable(job), "pending job changed")
    // Nothing is offered while reset is held.
    `TSF_ASSERT_ALWAYS(a_reset_quiet, !aresetn |=> !m_tvalid, "output valid right after reset")

endmodule

>>> tb/tb_tape_sector_framer.sv
`timescale 1ns / 100ps
// Self-checking testbench for the tape sector framer with random idling on both streams.
module tb_tape_sector_framer;

    localparam int unsigned HEAD_LEN       = 14;
    localparam int unsigned BLOCK_LEN      = 2;
    localparam int unsigned DATA_LEN       = 512;
    localparam int unsigned DATA_SENT      = 314;
    localparam logic [6:0]  HEAD_PREAMBLE  = 7'd10;
    localparam logic [6:0]  DATA_PREAMBLE  = 7'd6;
    localparam logic [6:0]  SYNC_RUN       = 7'd2;
    localparam logic [6:0]  FILL_RUN       = 7'd120;
    localparam logic [7:0]  SYNC_VALUE     = 8'hFF;
    localparam logic [7:0]  FILL_VALUE     = 8'h5A;
    localparam logic [15:0] CHECK_START    = 16'h0F0F;
    localparam int unsigned QUIET_TAIL     = 150;
    localparam int unsigned WATCHDOG_LIMIT = 500;
    localparam int unsigned DRAIN_CYCLES   = 8;

    typedef enum logic [1:0] {
        SEC_HEAD  = 2'd0,
        SEC_BLOCK = 2'd1,
        SEC_DATA  = 2'd2
    } section_e;

    typedef struct packed {
        logic [7:0] value;
        logic [6:0] count;
        logic       done;
        logic       last;
    } tape_run_t;

    logic                         aclk;
    logic                         aresetn;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [tsf_pkg::BYTE_W-1:0]   s_tdata;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [tsf_pkg::M_DATA_W-1:0] m_tdata;
    logic                         m_tuser;
    logic                         m_tlast;

    logic [7:0]  pending_bytes [$];
    tape_run_t   tape_runs [$];
    tape_run_t   want_run;

    section_e    cur_section = SEC_HEAD;
    logic [9:0]  section_pos = '0;
    logic [15:0] check_sum   = CHECK_START;

    bit          live;
    bit          s_took;
    int unsigned s_gap;
    int unsigned m_gap;
    int unsigned quiet_cycles;
    int unsigned mismatches;
    int unsigned bytes_framed;
    int unsigned runs_checked;
    int unsigned fills_checked;

    tape_sector_framer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("MISMATCH at run %0d, %s: got 0x%0h, want 0x%0h",
                 runs_checked, what, got, want);
        mismatches++;
    endtask

    // Works out the runs that one sector byte produces and queues them in order.
    task automatic frame_byte(input logic [7:0] b);
        tape_run_t   batch [6];
        int          n;
        int unsigned sec_len;
        logic [6:0]  preamble;
        n = 0;
        case (cur_section)
            SEC_BLOCK: begin
                sec_len  = BLOCK_LEN;
                preamble = HEAD_PREAMBLE;
            end
            SEC_DATA: begin
                sec_len  = DATA_LEN;
                preamble = DATA_PREAMBLE;
            end
            default: begin
                sec_len  = HEAD_LEN;
                preamble = HEAD_PREAMBLE;
            end
        endcase

        if (section_pos == 0) begin
            check_sum = CHECK_START;
            batch[n]  = '{value: 8'h00, count: preamble, done: 1'b0, last: 1'b0};
            n++;
            batch[n]  = '{value: SYNC_VALUE, count: SYNC_RUN, done: 1'b0, last: 1'b0};
            n++;
        end
        batch[n]  = '{value: b, count: 7'd1, done: 1'b0, last: 1'b0};
        n++;
        check_sum = check_sum + 16'(b);

        if (int'(section_pos) + 1 >= sec_len) begin
            batch[n] = '{value: check_sum[7:0], count: 7'd1, done: 1'b0, last: 1'b0};
            n++;
            batch[n] = '{value: check_sum[15:8], count: 7'd1, done: 1'b0, last: 1'b0};
            n++;
            case (cur_section)
                SEC_BLOCK: cur_section = SEC_DATA;
                SEC_DATA: begin
                    batch[n]    = '{value: FILL_VALUE, count: FILL_RUN, done: 1'b1,
                                    last: 1'b0};
                    n++;
                    cur_section = SEC_HEAD;
                end
                default: cur_section = SEC_BLOCK;
            endcase
            section_pos = '0;
            check_sum   = CHECK_START;
        end else begin
            section_pos = section_pos + 10'd1;
        end

        batch[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            tape_runs.push_back(batch[i]);
    endtask

    // Sender and receiver, both changing their outputs at the falling edge.
    always @(negedge aclk) begin
        if (live && (!s_tvalid || s_took)) begin
            if (s_gap != 0) begin
                s_tvalid <= 1'b0;
                s_gap = s_gap - 1;
            end else if (pending_bytes.size() != 0) begin
                s_tdata  <= pending_bytes.pop_front();
                s_tvalid <= 1'b1;
                if (pending_bytes.size() > QUIET_TAIL && $urandom_range(0, 5) == 0)
                    s_gap = $urandom_range(1, 9);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        if (live) begin
            if (m_gap != 0) begin
                m_tready <= 1'b0;
                m_gap = m_gap - 1;
            end else begin
                m_tready <= 1'b1;
                if (pending_bytes.size() > QUIET_TAIL && $urandom_range(0, 6) == 0)
                    m_gap = $urandom_range(1, 9);
            end
        end
    end

    // Both channels are sampled at the rising edge, before the block updates.
    always @(posedge aclk) begin
        live   = aresetn;
        s_took = aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (s_took) begin
                frame_byte(s_tdata);
                bytes_framed++;
            end
            if (m_tvalid && m_tready) begin
                runs_checked++;
                if (tape_runs.size() == 0) begin
                    report_mismatch("result with nothing expected", m_tdata, 0);
                end else begin
                    want_run = tape_runs.pop_front();
                    if (m_tdata[7:0] != want_run.value)
                        report_mismatch("out_byte", m_tdata[7:0], want_run.value);
                    if (m_tdata[14:8] != want_run.count)
                        report_mismatch("repeat_count", m_tdata[14:8], want_run.count);
                    if (m_tuser != want_run.done)
                        report_mismatch("sector_done", m_tuser, want_run.done);
                    if (m_tlast != want_run.last)
                        report_mismatch("last_of_run", m_tlast, want_run.last);
                    if (want_run.done)
                        fills_checked++;
                end
            end
            if (s_took || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no transfer on either stream for %0d cycles",
                         quiet_cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;

        // First sector header walks the single-bit values and both extremes.
        pending_bytes = '{8'h00, 8'hFF, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20,
                          8'h40, 8'h80, 8'h7F, 8'hFE, 8'hAA, 8'h55,
                          8'hFF, 8'h00,
                          8'hFF, 8'h00, 8'h80, 8'h01, 8'hFF, 8'hFF, 8'h7F};
        // The run goes on part way into the data section, with the later bytes
        // heavy in high values.
        for (int i = 7; i < DATA_SENT; i++)
            pending_bytes.push_back(i < DATA_SENT / 2 ? 8'($urandom_range(0, 255))
                                                      : 8'($urandom_range(224, 255)));

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (pending_bytes.size() != 0 || s_tvalid || tape_runs.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);

        $display("Framed %0d sector bytes and checked %0d runs.", bytes_framed, runs_checked);
        $display("Closed %0d sectors with filler; %0d field mismatches.",
                 fills_checked, mismatches);
        if (mismatches == 0 && tape_runs.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> tape_sector_framer.f
+incdir+hw/rtl
hw/rtl/tsf_pkg.sv
hw/rtl/tsf_sectioner.sv
hw/rtl/tsf_emitter.sv
hw/rtl/tape_sector_framer.sv
tb/tb_tape_sector_framer.sv
